@@ rtl/core/srb_pkg.sv @@
// Shared types and constants for the sequence reorder buffer.
package srb_pkg;

	localparam int WINDOW_DEF = 64;

	localparam logic [2:0] ST_SHORT     = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_DELIVERED = 3'd2;
	localparam logic [2:0] ST_HELD      = 3'd3;
	localparam logic [2:0] ST_BEYOND    = 3'd4;

	typedef struct packed {
		logic        header_complete;
		logic [63:0] sequence_req;
		logic [31:0] payload_bytes;
	} srb_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  released_count;
		logic [63:0] delivered_total;
		logic [63:0] expected_next;
		logic [63:0] out_of_order_total;
		logic [63:0] duplicate_total;
	} srb_out_t;

endpackage

@@ rtl/core/srb_front.sv @@
// Front end: accepts headers and holds them in a two-entry queue.
module srb_front import srb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  srb_in_t in_data,
	output logic    q_valid,
	input  logic    q_ready,
	output srb_in_t q_data
);

	srb_in_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

@@ rtl/core/srb_back.sv @@
// Back end: classifies, holds and drains out-of-order packets.
module srb_back import srb_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	output logic     q_ready,
	input  srb_in_t  q_data,
	output logic     out_valid,
	input  logic     out_ready,
	output srb_out_t out_data
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LOOK  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]        state_q;
	logic [63:0]       next_q, dlv_q, ooo_q, dup_q;
	logic [WINDOW-1:0] valid_q;
	logic [31:0]       bytes_mem [WINDOW];
	logic [31:0]       rd_q;
	logic [6:0]        rel_q;
	logic              ov_q;
	srb_out_t          od_q;

	logic [63:0]   gap;
	logic [IW-1:0] idx, nidx, nnidx;
	logic          take, in_win;

	assign take    = (state_q == S_IDLE) && q_valid && !ov_q;
	assign q_ready = take;
	assign gap     = q_data.sequence_req - next_q;
	assign in_win  = (gap < 64'(WINDOW));
	assign idx     = IW'(q_data.sequence_req % 64'(WINDOW));
	assign nidx    = IW'(next_q % 64'(WINDOW));
	assign nnidx   = IW'((next_q + 64'd1) % 64'(WINDOW));
	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_ff @(posedge clk) begin
		if (take && q_data.header_complete && q_data.sequence_req >= next_q && in_win
			&& !valid_q[idx] && gap != 64'd0)
			bytes_mem[idx] <= q_data.payload_bytes;
		rd_q <= bytes_mem[(state_q == S_IDLE) ? nnidx : nidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			next_q  <= '0;
			dlv_q   <= '0;
			ooo_q   <= '0;
			dup_q   <= '0;
			valid_q <= '0;
			rel_q   <= '0;
			ov_q    <= 1'b0;
			od_q    <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						od_q.released_count     <= 7'd0;
						od_q.delivered_total    <= dlv_q;
						od_q.expected_next      <= next_q;
						if (!q_data.header_complete) begin
							od_q.status <= ST_SHORT;
							od_q.out_of_order_total <= ooo_q;
							od_q.duplicate_total    <= dup_q;
							ov_q <= 1'b1;
						end else if (q_data.sequence_req < next_q) begin
							dup_q <= dup_q + 64'd1;
							od_q.status <= ST_DUP;
							od_q.out_of_order_total <= ooo_q;
							od_q.duplicate_total <= dup_q + 64'd1;
							ov_q <= 1'b1;
						end else if (!in_win) begin
							od_q.status <= ST_BEYOND;
							od_q.out_of_order_total <= ooo_q;
							od_q.duplicate_total    <= dup_q;
							ov_q <= 1'b1;
						end else if (valid_q[idx]) begin
							dup_q <= dup_q + 64'd1;
							od_q.status <= ST_DUP;
							od_q.out_of_order_total <= ooo_q;
							od_q.duplicate_total <= dup_q + 64'd1;
							ov_q <= 1'b1;
						end else if (gap != 64'd0) begin
							valid_q[idx] <= 1'b1;
							ooo_q <= ooo_q + 64'd1;
							od_q.status <= ST_HELD;
							od_q.out_of_order_total <= ooo_q + 64'd1;
							od_q.duplicate_total    <= dup_q;
							ov_q <= 1'b1;
						end else begin
							dlv_q   <= dlv_q + 64'(q_data.payload_bytes);
							next_q  <= next_q + 64'd1;
							rel_q   <= 7'd1;
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK, S_DRAIN: begin
					if (state_q == S_DRAIN || !valid_q[nidx]) begin
						if (valid_q[nidx]) begin
							valid_q[nidx] <= 1'b0;
							dlv_q  <= dlv_q + 64'(rd_q);
							next_q <= next_q + 64'd1;
							rel_q  <= rel_q + 7'd1;
							state_q <= S_LOOK;
						end else begin
							od_q.status             <= ST_DELIVERED;
							od_q.released_count     <= rel_q;
							od_q.delivered_total    <= dlv_q;
							od_q.expected_next      <= next_q;
							od_q.out_of_order_total <= ooo_q;
							od_q.duplicate_total    <= dup_q;
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_DRAIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/sequence_reorder_buffer.sv @@
// Top level of the sequence reorder buffer.
// Use: packet headers enter on in_valid/in_ready as srb_in_t beats; one
// result per header leaves on out_valid/out_ready as an srb_out_t beat.
// A two-entry queue sits between the accepting front end and the back end,
// so headers are taken while the back end is busy or the result is stalled.
// Flow: short, duplicate, held and beyond-window headers are classified in
// the idle state and give a registered result. An in-order header passes
// through a look state, then a drain state for each held successor drained;
// the drain reads a slot of the byte store (registered read then accumulate).
// The back end takes no new header while it drains an in-order header or
// while its last result still waits for the receiver.
// Reset clears the expected sequence, all counters and every slot's valid
// bit at once; no clearing pass is needed.
// When the receiver stalls the result register holds and the back end stops
// taking from the queue; the front end fills and then drops in_ready.
module sequence_reorder_buffer import srb_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  srb_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output srb_out_t out_data
);

	logic    q_valid, q_ready;
	srb_in_t q_data;

	srb_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid, .q_ready, .q_data
	);

	srb_back #(.WINDOW(WINDOW)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);

endmodule
